### rtl/mjpid_pkg.sv
// mjpid_pkg: widths, register codes and pipeline payload types for the
// multi-joint pid controller; no dependencies, used by every rtl file
`timescale 1ns / 1ps
`default_nettype none

package mjpid_pkg;

    localparam int JOINT_COUNT = 4;
    localparam int JOINT_W     = 2;
    localparam int ANGLE_W     = 24;
    localparam int ERR_W       = 25;
    localparam int DIFF_W      = 26;
    localparam int SUM_W       = 40;
    localparam int GAIN_W      = 24;
    localparam int LIMIT_W     = 15;
    localparam int DRIVE_W     = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    // split of the integral multiply into two narrow products
    localparam int SUM_LO_W    = 16;
    localparam int SUM_HI_W    = SUM_W - SUM_LO_W;
    localparam int P_W         = GAIN_W + ERR_W;
    localparam int D_W         = GAIN_W + DIFF_W;
    localparam int IHI_W       = GAIN_W + SUM_HI_W;
    localparam int ILO_W       = GAIN_W + SUM_LO_W;
    localparam int ITERM_W     = IHI_W + SUM_LO_W;
    localparam int ICAP_W      = 54;
    localparam int PD_W        = 51;
    localparam int TOTAL_W     = 56;
    localparam int FRAC_SHIFT  = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_KP           = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI_DT        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD_OVER_DT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT = 2'd3;

    localparam logic [GAIN_W-1:0]  KP_RESET           = 24'd229376;
    localparam logic [GAIN_W-1:0]  KI_DT_RESET        = 24'd0;
    localparam logic [GAIN_W-1:0]  KD_OVER_DT_RESET   = 24'd26214;
    localparam logic [LIMIT_W-1:0] OUTPUT_LIMIT_RESET = 15'd25600;

    typedef struct packed {
        logic [GAIN_W-1:0]  kp;
        logic [GAIN_W-1:0]  ki_dt;
        logic [GAIN_W-1:0]  kd_over_dt;
        logic [LIMIT_W-1:0] output_limit;
    } t_cfg;

    typedef struct packed {
        logic [JOINT_W-1:0]       joint;
        logic                     in_range;
        logic signed [ERR_W-1:0]  err;
        logic signed [SUM_W-1:0]  sum;
        logic signed [DIFF_W-1:0] diff;
    } t_err;

    typedef struct packed {
        logic [JOINT_W-1:0]        joint;
        logic                      in_range;
        logic signed [TOTAL_W-1:0] total;
    } t_total;

endpackage

`default_nettype wire

### rtl/multi_joint_pid_controller_unit.sv
// multi_joint_pid_controller_unit: top level with gain registers, input
// register and the pid pipeline; depends on mjpid_pkg, mjpid_err_stage,
// mjpid_mac and mjpid_clamp
`timescale 1ns / 1ps
`default_nettype none

// Positional PID for four joints, one control tick per transfer. A tick is
// taken every cycle while the output does not stall; its drive value reaches
// the result register in input order, after the input register and the
// mac stages. The per-joint error sum and last error are updated in the
// first stage, in the same cycle the tick moves on, so ticks for the same
// joint may follow each other back to back. The product stage, the integral
// recombine, the cap and sum stage and the clamp stage follow the first
// stage. Both per-joint stores clear at reset. Gains and the output limit
// are to be written through the plain write port only while no tick is in
// flight; the block itself does not enforce this.

module multi_joint_pid_controller_unit (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic [mjpid_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [mjpid_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic [mjpid_pkg::JOINT_W-1:0]          i_joint,
    input  wire logic signed [mjpid_pkg::ANGLE_W-1:0]   i_target_angle,
    input  wire logic signed [mjpid_pkg::ANGLE_W-1:0]   i_measured_angle,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic [mjpid_pkg::JOINT_W-1:0]               o_joint_out,
    output logic signed [mjpid_pkg::DRIVE_W-1:0]        o_drive,
    output logic                                        o_clamped
);

    mjpid_pkg::t_cfg   r_cfg;
    mjpid_pkg::t_err   w_err;
    mjpid_pkg::t_total w_total;

    logic                                   r_a_valid;
    logic [mjpid_pkg::JOINT_W-1:0]          r_a_joint;
    logic signed [mjpid_pkg::ANGLE_W-1:0]   r_a_target;
    logic signed [mjpid_pkg::ANGLE_W-1:0]   r_a_measured;
    logic                                   w_mac_ready;
    logic                                   w_a_move;
    logic                                   w_total_valid;
    logic                                   w_clamp_ready;
    logic signed [mjpid_pkg::DRIVE_W-1:0]   w_lim16;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp           <= mjpid_pkg::KP_RESET;
            r_cfg.ki_dt        <= mjpid_pkg::KI_DT_RESET;
            r_cfg.kd_over_dt   <= mjpid_pkg::KD_OVER_DT_RESET;
            r_cfg.output_limit <= mjpid_pkg::OUTPUT_LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mjpid_pkg::CFG_KP: begin
                    r_cfg.kp <= i_cfg_data[mjpid_pkg::GAIN_W-1:0];
                end
                mjpid_pkg::CFG_KI_DT: begin
                    r_cfg.ki_dt <= i_cfg_data[mjpid_pkg::GAIN_W-1:0];
                end
                mjpid_pkg::CFG_KD_OVER_DT: begin
                    r_cfg.kd_over_dt <= i_cfg_data[mjpid_pkg::GAIN_W-1:0];
                end
                mjpid_pkg::CFG_OUTPUT_LIMIT: begin
                    r_cfg.output_limit <= i_cfg_data[mjpid_pkg::LIMIT_W-1:0];
                end
            endcase
        end
    end

    // input register
    assign o_in_ready = !r_a_valid || w_mac_ready;
    assign w_a_move   = r_a_valid && w_mac_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_a_joint    <= i_joint;
            r_a_target   <= i_target_angle;
            r_a_measured <= i_measured_angle;
        end
    end

    mjpid_err_stage u_err (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (w_a_move),
        .i_joint          (r_a_joint),
        .i_target_angle   (r_a_target),
        .i_measured_angle (r_a_measured),
        .o_err            (w_err)
    );

    mjpid_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (r_a_valid),
        .o_ready (w_mac_ready),
        .i_err   (w_err),
        .o_valid (w_total_valid),
        .i_ready (w_clamp_ready),
        .o_total (w_total)
    );

    mjpid_clamp u_clamp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_limit   (r_cfg.output_limit),
        .i_valid   (w_total_valid),
        .o_ready   (w_clamp_ready),
        .i_total   (w_total),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_joint   (o_joint_out),
        .o_drive   (o_drive),
        .o_clamped (o_clamped)
    );

    assign w_lim16 = $signed({1'b0, r_cfg.output_limit});

    a_clamp_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_clamped) |-> (o_drive == w_lim16 || o_drive == -w_lim16))
        else $error("clamped drive not at the limit");

    a_drive_within: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_clamped) |-> (o_drive <= w_lim16 && o_drive >= -w_lim16))
        else $error("unclamped drive beyond the limit");

    a_empty_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with an empty result register");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire

### rtl/mjpid_err_stage.sv
// mjpid_err_stage: per-joint error sum and last error stores, error,
// saturating sum and difference for the item in the input register
// depends on mjpid_pkg
`timescale 1ns / 1ps
`default_nettype none

module mjpid_err_stage (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_load,
    input  wire logic [mjpid_pkg::JOINT_W-1:0]            i_joint,
    input  wire logic signed [mjpid_pkg::ANGLE_W-1:0]     i_target_angle,
    input  wire logic signed [mjpid_pkg::ANGLE_W-1:0]     i_measured_angle,
    output mjpid_pkg::t_err                               o_err
);

    localparam int RAW_W = mjpid_pkg::SUM_W + 1;

    logic signed [mjpid_pkg::SUM_W-1:0] r_sum  [mjpid_pkg::JOINT_COUNT];
    logic signed [mjpid_pkg::ERR_W-1:0] r_last [mjpid_pkg::JOINT_COUNT];

    logic                                w_in_range;
    logic signed [mjpid_pkg::ERR_W-1:0]  w_err;
    logic signed [RAW_W-1:0]             w_raw;
    logic signed [mjpid_pkg::SUM_W-1:0]  n_sum;
    logic signed [mjpid_pkg::DIFF_W-1:0] w_diff;

    assign w_in_range = {1'b0, i_joint} < (mjpid_pkg::JOINT_W + 1)'(mjpid_pkg::JOINT_COUNT);
    assign w_err  = mjpid_pkg::ERR_W'(i_target_angle) - mjpid_pkg::ERR_W'(i_measured_angle);
    assign w_raw  = RAW_W'(r_sum[i_joint]) + RAW_W'(w_err);
    assign w_diff = mjpid_pkg::DIFF_W'(w_err) - mjpid_pkg::DIFF_W'(r_last[i_joint]);

    always_comb begin
        // saturate when the two top bits disagree
        if (w_raw[RAW_W-1] != w_raw[RAW_W-2]) begin
            n_sum = w_raw[RAW_W-1] ? {1'b1, {(mjpid_pkg::SUM_W-1){1'b0}}}
                                   : {1'b0, {(mjpid_pkg::SUM_W-1){1'b1}}};
        end else begin
            n_sum = w_raw[mjpid_pkg::SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < mjpid_pkg::JOINT_COUNT; k++) begin
                r_sum[k]  <= '0;
                r_last[k] <= '0;
            end
        end else if (i_load && w_in_range) begin
            r_sum[i_joint]  <= n_sum;
            r_last[i_joint] <= w_err;
        end
    end

    assign o_err.joint    = i_joint;
    assign o_err.in_range = w_in_range;
    assign o_err.err      = w_err;
    assign o_err.sum      = n_sum;
    assign o_err.diff     = w_diff;

endmodule

`default_nettype wire

### rtl/mjpid_mac.sv
// mjpid_mac: pipelined gain multiplies and term summation with integral cap
// four register stages with per-stage valid and ready; depends on mjpid_pkg
`timescale 1ns / 1ps
`default_nettype none

module mjpid_mac (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire mjpid_pkg::t_cfg i_cfg,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire mjpid_pkg::t_err i_err,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output mjpid_pkg::t_total    o_total
);

    typedef struct packed {
        logic [mjpid_pkg::JOINT_W-1:0]      joint;
        logic                               in_range;
        logic signed [mjpid_pkg::P_W-1:0]   p;
        logic signed [mjpid_pkg::D_W-1:0]   d;
        logic signed [mjpid_pkg::IHI_W-1:0] ihi;
        logic [mjpid_pkg::ILO_W-1:0]        ilo;
    } t_prod;

    typedef struct packed {
        logic [mjpid_pkg::JOINT_W-1:0]        joint;
        logic                                 in_range;
        logic signed [mjpid_pkg::ITERM_W-1:0] iterm;
        logic signed [mjpid_pkg::PD_W-1:0]    pd;
    } t_part;

    localparam logic signed [mjpid_pkg::ITERM_W-1:0] ICAP_POS =
        mjpid_pkg::ITERM_W'(1) <<< (mjpid_pkg::ICAP_W - 2);
    localparam logic signed [mjpid_pkg::ITERM_W-1:0] ICAP_NEG = -ICAP_POS;

    mjpid_pkg::t_err   r_b;
    t_prod             r_c;
    t_prod             n_c;
    t_part             r_d;
    t_part             n_d;
    mjpid_pkg::t_total r_e;
    mjpid_pkg::t_total n_e;
    logic              r_b_valid, r_c_valid, r_d_valid, r_e_valid;
    logic              w_b_ready, w_c_ready, w_d_ready, w_e_ready;

    logic signed [mjpid_pkg::ICAP_W-1:0] w_icap;

    assign w_e_ready = !r_e_valid || i_ready;
    assign w_d_ready = !r_d_valid || w_e_ready;
    assign w_c_ready = !r_c_valid || w_d_ready;
    assign w_b_ready = !r_b_valid || w_c_ready;

    // products
    always_comb begin
        n_c.joint    = r_b.joint;
        n_c.in_range = r_b.in_range;
        n_c.p   = $signed({1'b0, i_cfg.kp}) * r_b.err;
        n_c.d   = $signed({1'b0, i_cfg.kd_over_dt}) * r_b.diff;
        n_c.ihi = $signed({1'b0, i_cfg.ki_dt})
                * $signed(r_b.sum[mjpid_pkg::SUM_W-1:mjpid_pkg::SUM_LO_W]);
        n_c.ilo = i_cfg.ki_dt * r_b.sum[mjpid_pkg::SUM_LO_W-1:0];
    end

    // integral recombine, proportional plus derivative
    always_comb begin
        n_d.joint    = r_c.joint;
        n_d.in_range = r_c.in_range;
        n_d.iterm = $signed({r_c.ihi, {mjpid_pkg::SUM_LO_W{1'b0}}})
                  + $signed({{(mjpid_pkg::ITERM_W - mjpid_pkg::ILO_W){1'b0}}, r_c.ilo});
        n_d.pd = mjpid_pkg::PD_W'(r_c.p) + mjpid_pkg::PD_W'(r_c.d);
    end

    // integral cap and final sum
    always_comb begin
        priority if (r_d.iterm > ICAP_POS) begin
            w_icap = ICAP_POS[mjpid_pkg::ICAP_W-1:0];
        end else if (r_d.iterm < ICAP_NEG) begin
            w_icap = ICAP_NEG[mjpid_pkg::ICAP_W-1:0];
        end else begin
            w_icap = r_d.iterm[mjpid_pkg::ICAP_W-1:0];
        end
        n_e.joint    = r_d.joint;
        n_e.in_range = r_d.in_range;
        n_e.total    = mjpid_pkg::TOTAL_W'(r_d.pd) + mjpid_pkg::TOTAL_W'(w_icap);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else begin
            if (w_b_ready) r_b_valid <= i_valid;
            if (w_c_ready) r_c_valid <= r_b_valid;
            if (w_d_ready) r_d_valid <= r_c_valid;
            if (w_e_ready) r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_ready && i_valid)   r_b <= i_err;
        if (w_c_ready && r_b_valid) r_c <= n_c;
        if (w_d_ready && r_c_valid) r_d <= n_d;
        if (w_e_ready && r_d_valid) r_e <= n_e;
    end

    assign o_ready = w_b_ready;
    assign o_valid = r_e_valid;
    assign o_total = r_e;

endmodule

`default_nettype wire

### rtl/mjpid_clamp.sv
// mjpid_clamp: symmetric limit, rounding to q8.8 and the result register
// depends on mjpid_pkg
`timescale 1ns / 1ps
`default_nettype none

module mjpid_clamp (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic [mjpid_pkg::LIMIT_W-1:0]        i_limit,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire mjpid_pkg::t_total                    i_total,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic [mjpid_pkg::JOINT_W-1:0]             o_joint,
    output logic signed [mjpid_pkg::DRIVE_W-1:0]      o_drive,
    output logic                                      o_clamped
);

    localparam logic signed [mjpid_pkg::TOTAL_W-1:0] HALF =
        mjpid_pkg::TOTAL_W'(1) <<< (mjpid_pkg::FRAC_SHIFT - 1);

    logic                                 r_valid;
    logic [mjpid_pkg::JOINT_W-1:0]        r_joint;
    logic signed [mjpid_pkg::DRIVE_W-1:0] r_drive;
    logic                                 r_clamped;
    logic signed [mjpid_pkg::DRIVE_W-1:0] n_drive;
    logic                                 n_clamped;

    logic signed [mjpid_pkg::TOTAL_W-1:0] w_lim;
    logic signed [mjpid_pkg::TOTAL_W-1:0] w_rnd;
    logic signed [mjpid_pkg::DRIVE_W-1:0] w_lim16;

    assign w_lim   = mjpid_pkg::TOTAL_W'($signed({1'b0, i_limit,
                                                  {mjpid_pkg::FRAC_SHIFT{1'b0}}}));
    assign w_rnd   = (i_total.total + HALF) >>> mjpid_pkg::FRAC_SHIFT;
    assign w_lim16 = $signed({1'b0, i_limit});
    assign o_ready = !r_valid || i_ready;

    always_comb begin
        priority if (!i_total.in_range) begin
            n_drive   = '0;
            n_clamped = 1'b0;
        end else if (i_total.total > w_lim) begin
            n_drive   = w_lim16;
            n_clamped = 1'b1;
        end else if (i_total.total < -w_lim) begin
            n_drive   = -w_lim16;
            n_clamped = 1'b1;
        end else begin
            n_drive   = w_rnd[mjpid_pkg::DRIVE_W-1:0];
            n_clamped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_joint   <= i_total.joint;
            r_drive   <= n_drive;
            r_clamped <= n_clamped;
        end
    end

    assign o_valid   = r_valid;
    assign o_joint   = r_joint;
    assign o_drive   = r_drive;
    assign o_clamped = r_clamped;

endmodule

`default_nettype wire

### tb/mjpid_drive_checker.sv
`timescale 1ns / 1ps
// mjpid_drive_checker: watches the register write port and both transfer
// channels of the pid unit, predicts each drive value and compares it
// depends on mjpid_pkg

module mjpid_drive_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [mjpid_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mjpid_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                   i_in_valid,
    input  logic                                   i_in_ready,
    input  logic [mjpid_pkg::JOINT_W-1:0]          i_joint,
    input  logic signed [mjpid_pkg::ANGLE_W-1:0]   i_target_angle,
    input  logic signed [mjpid_pkg::ANGLE_W-1:0]   i_measured_angle,
    input  logic                                   i_out_valid,
    input  logic                                   i_out_ready,
    input  logic [mjpid_pkg::JOINT_W-1:0]          i_joint_out,
    input  logic signed [mjpid_pkg::DRIVE_W-1:0]   i_drive,
    input  logic                                   i_clamped,
    output int                                     o_mismatches,
    output int                                     o_outstanding,
    output int                                     o_compared
);

    localparam int WIDE_W = 80;
    typedef logic signed [WIDE_W-1:0] t_wide;

    localparam t_wide SUM_TOP    = (t_wide'(1) <<< (mjpid_pkg::SUM_W - 1)) - 1;
    localparam t_wide SUM_BOTTOM = -(t_wide'(1) <<< (mjpid_pkg::SUM_W - 1));
    localparam t_wide ITERM_PIN  = t_wide'(1) <<< 52;
    localparam t_wide HALF_LSB   = t_wide'(1) <<< (mjpid_pkg::FRAC_SHIFT - 1);
    localparam int    MAX_REPORTS = 20;

    typedef struct packed {
        logic [mjpid_pkg::JOINT_W-1:0]        joint;
        logic signed [mjpid_pkg::DRIVE_W-1:0] drive;
        logic                                 clamped;
    } t_drive_result;

    mjpid_pkg::t_cfg gains;
    logic signed [mjpid_pkg::SUM_W-1:0] error_total [mjpid_pkg::JOINT_COUNT];
    logic signed [mjpid_pkg::ERR_W-1:0] prior_error [mjpid_pkg::JOINT_COUNT];
    t_drive_result awaited_drives [$];
    int mismatch_count = 0;
    int compare_count = 0;
    int outstanding = 0;

    assign o_mismatches  = mismatch_count;
    assign o_outstanding = outstanding;
    assign o_compared    = compare_count;

    // one control tick: updates the joint's integrator and last error
    function automatic t_drive_result pid_drive(input logic [mjpid_pkg::JOINT_W-1:0] joint,
                                                input logic signed [mjpid_pkg::ANGLE_W-1:0] tgt,
                                                input logic signed [mjpid_pkg::ANGLE_W-1:0] meas);
        t_wide err, sum, pterm, iterm, dterm, total, lim, rounded;
        t_drive_result r;
        r.joint   = joint;
        r.drive   = '0;
        r.clamped = 1'b0;
        if (int'(joint) >= mjpid_pkg::JOINT_COUNT)
            return r;
        err = t_wide'(tgt) - t_wide'(meas);
        sum = t_wide'(error_total[joint]) + err;
        if (sum > SUM_TOP)
            sum = SUM_TOP;
        if (sum < SUM_BOTTOM)
            sum = SUM_BOTTOM;
        pterm = t_wide'({1'b0, gains.kp}) * err;
        iterm = t_wide'({1'b0, gains.ki_dt}) * sum;
        if (iterm > ITERM_PIN)
            iterm = ITERM_PIN;
        if (iterm < -ITERM_PIN)
            iterm = -ITERM_PIN;
        dterm = t_wide'({1'b0, gains.kd_over_dt}) * (err - t_wide'(prior_error[joint]));
        total = pterm + iterm + dterm;
        error_total[joint] = sum[mjpid_pkg::SUM_W-1:0];
        prior_error[joint] = err[mjpid_pkg::ERR_W-1:0];
        lim = t_wide'({1'b0, gains.output_limit}) <<< mjpid_pkg::FRAC_SHIFT;
        if (total > lim) begin
            rounded   = t_wide'({1'b0, gains.output_limit});
            r.clamped = 1'b1;
        end else if (total < -lim) begin
            rounded   = -t_wide'({1'b0, gains.output_limit});
            r.clamped = 1'b1;
        end else begin
            // round half toward plus infinity
            rounded = (total + HALF_LSB) >>> mjpid_pkg::FRAC_SHIFT;
        end
        r.drive = rounded[mjpid_pkg::DRIVE_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_drive_result want;
        t_drive_result got;
        if (!i_rst_n) begin
            gains.kp           = mjpid_pkg::KP_RESET;
            gains.ki_dt        = mjpid_pkg::KI_DT_RESET;
            gains.kd_over_dt   = mjpid_pkg::KD_OVER_DT_RESET;
            gains.output_limit = mjpid_pkg::OUTPUT_LIMIT_RESET;
            for (int j = 0; j < mjpid_pkg::JOINT_COUNT; j++) begin
                error_total[j] = '0;
                prior_error[j] = '0;
            end
            awaited_drives.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.joint   = i_joint_out;
                got.drive   = i_drive;
                got.clamped = i_clamped;
                if (awaited_drives.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"%0t: drive transfer with no tick outstanding: ",
                                  "joint %0d drive %0d clamped %0d"},
                                 $time, got.joint, got.drive, got.clamped);
                end else begin
                    want = awaited_drives.pop_front();
                    compare_count++;
                    if (got != want) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display({"%0t: expected joint %0d drive %0d clamped %0d, ",
                                      "got joint %0d drive %0d clamped %0d"},
                                     $time, want.joint, want.drive, want.clamped,
                                     got.joint, got.drive, got.clamped);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                awaited_drives.push_back(pid_drive(i_joint, i_target_angle, i_measured_angle));
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mjpid_pkg::CFG_KP:           gains.kp = i_cfg_data;
                    mjpid_pkg::CFG_KI_DT:        gains.ki_dt = i_cfg_data;
                    mjpid_pkg::CFG_KD_OVER_DT:   gains.kd_over_dt = i_cfg_data;
                    mjpid_pkg::CFG_OUTPUT_LIMIT:
                        gains.output_limit = i_cfg_data[mjpid_pkg::LIMIT_W-1:0];
                    default: ;
                endcase
            end
        end
        outstanding <= awaited_drives.size();
    end

endmodule

### tb/multi_joint_pid_controller_unit_tb.sv
`timescale 1ns / 1ps
// multi_joint_pid_controller_unit_tb: clock, reset, gain writes and tick
// stimulus with random stalls on both channels; depends on mjpid_pkg, the
// pid unit and mjpid_drive_checker

module multi_joint_pid_controller_unit_tb;

    typedef enum int {PACE_FULL, PACE_LIGHT, PACE_HEAVY} t_pace;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 200;
    localparam int QUIET_LIMIT   = 3000;
    localparam int RAMP_TICKS    = 8;
    localparam int NUM_PHASES    = 7;
    localparam int PHASE_TICKS   = 260;

    localparam logic signed [mjpid_pkg::ANGLE_W-1:0] ANGLE_MAX = 24'sh7FFFFF;
    localparam logic signed [mjpid_pkg::ANGLE_W-1:0] ANGLE_MIN = 24'sh800000;
    localparam logic [mjpid_pkg::GAIN_W-1:0]  GAIN_MAX  = '1;
    localparam logic [mjpid_pkg::LIMIT_W-1:0] LIMIT_MAX = '1;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [mjpid_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mjpid_pkg::CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [mjpid_pkg::JOINT_W-1:0] joint;
    logic signed [mjpid_pkg::ANGLE_W-1:0] target_angle;
    logic signed [mjpid_pkg::ANGLE_W-1:0] measured_angle;
    logic out_valid;
    logic out_ready;
    logic [mjpid_pkg::JOINT_W-1:0] joint_out;
    logic signed [mjpid_pkg::DRIVE_W-1:0] drive;
    logic clamped;

    int mismatches;
    int outstanding;
    int compared;
    int ticks_sent = 0;
    int gain_sets = 0;
    int quiet_cycles = 0;
    t_pace src_pace = PACE_FULL;
    t_pace sink_pace = PACE_FULL;
    logic sink_steady = 1'b0;
    logic sink_hold_req = 1'b0;
    logic signed [mjpid_pkg::ANGLE_W-1:0] setpoint [mjpid_pkg::JOINT_COUNT];

    always #5 clk = ~clk;

    multi_joint_pid_controller_unit dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_joint          (joint),
        .i_target_angle   (target_angle),
        .i_measured_angle (measured_angle),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_joint_out      (joint_out),
        .o_drive          (drive),
        .o_clamped        (clamped)
    );

    mjpid_drive_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_joint          (joint),
        .i_target_angle   (target_angle),
        .i_measured_angle (measured_angle),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_joint_out      (joint_out),
        .i_drive          (drive),
        .i_clamped        (clamped),
        .o_mismatches     (mismatches),
        .o_outstanding    (outstanding),
        .o_compared       (compared)
    );

    function automatic int unsigned pick_gap(input t_pace pace);
        int unsigned roll;
        int unsigned gap;
        roll = $urandom_range(99);
        gap = 0;
        if (pace == PACE_LIGHT) begin
            if (roll >= 97)
                gap = $urandom_range(60, 12);
            else if (roll >= 80)
                gap = $urandom_range(3, 1);
        end else if (pace == PACE_HEAVY) begin
            if (roll >= 92)
                gap = $urandom_range(60, 12);
            else if (roll >= 45)
                gap = $urandom_range(4, 1);
        end
        return gap;
    endfunction

    function automatic logic [mjpid_pkg::GAIN_W-1:0] pick_gain();
        logic [mjpid_pkg::GAIN_W-1:0] g;
        case ($urandom_range(4))
            0:       g = '0;
            1:       g = GAIN_MAX;
            2:       g = 24'($urandom_range(32'h0002_0000));
            3:       g = 24'($urandom_range(32'h0000_2000));
            default: g = 24'($urandom);
        endcase
        return g;
    endfunction

    function automatic logic [mjpid_pkg::LIMIT_W-1:0] pick_limit();
        logic [mjpid_pkg::LIMIT_W-1:0] l;
        case ($urandom_range(3))
            0:       l = '0;
            1:       l = LIMIT_MAX;
            default: l = 15'($urandom);
        endcase
        return l;
    endfunction

    // all four registers, back to back, while nothing is in flight
    task automatic load_gains(input logic [mjpid_pkg::GAIN_W-1:0] kp,
                              input logic [mjpid_pkg::GAIN_W-1:0] ki_dt,
                              input logic [mjpid_pkg::GAIN_W-1:0] kd_over_dt,
                              input logic [mjpid_pkg::LIMIT_W-1:0] limit);
        logic [mjpid_pkg::CFG_DATA_W-1:0] vals [4];
        logic [mjpid_pkg::CFG_IDX_W-1:0] regs [4];
        int k;
        regs = '{mjpid_pkg::CFG_KP, mjpid_pkg::CFG_KI_DT,
                 mjpid_pkg::CFG_KD_OVER_DT, mjpid_pkg::CFG_OUTPUT_LIMIT};
        // bits above the limit field are don't care
        vals = '{kp, ki_dt, kd_over_dt, {9'($urandom), limit}};
        cfg_we <= 1'b1;
        for (k = 0; k < 4; k++) begin
            cfg_index <= regs[k];
            cfg_data  <= vals[k];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        gain_sets++;
    endtask

    task automatic send_tick(input logic [mjpid_pkg::JOINT_W-1:0] j,
                             input logic signed [mjpid_pkg::ANGLE_W-1:0] tgt,
                             input logic signed [mjpid_pkg::ANGLE_W-1:0] meas);
        int unsigned gap;
        gap = pick_gap(src_pace);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        joint          <= j;
        target_angle   <= tgt;
        measured_angle <= meas;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        ticks_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mostly a joint tracking its setpoint, sometimes raw noise
    task automatic tracking_tick();
        logic [mjpid_pkg::JOINT_W-1:0] j;
        logic signed [mjpid_pkg::ANGLE_W-1:0] tgt;
        logic signed [mjpid_pkg::ANGLE_W-1:0] meas;
        int unsigned mag;
        int delta;
        j = mjpid_pkg::JOINT_W'($urandom_range(mjpid_pkg::JOINT_COUNT - 1));
        if ($urandom_range(99) < 10) begin
            tgt  = 24'($urandom);
            meas = 24'($urandom);
        end else begin
            if ($urandom_range(15) == 0)
                setpoint[j] = 24'($urandom);
            case ($urandom_range(3))
                0:       mag = 16;
                1:       mag = 1024;
                2:       mag = 65536;
                default: mag = 1 << 22;
            endcase
            delta = int'($urandom_range(2 * mag)) - int'(mag);
            tgt  = setpoint[j];
            meas = tgt - delta[mjpid_pkg::ANGLE_W-1:0];
        end
        send_tick(j, tgt, meas);
        if ($urandom_range(99) == 0)
            src_pace = t_pace'($urandom_range(2));
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin : sink
        int unsigned stall;
        out_ready = 1'b0;
        @(posedge clk);
        forever begin
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = pick_gap(sink_pace);
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            if (!sink_steady && $urandom_range(199) == 0)
                sink_pace = t_pace'($urandom_range(2));
        end
    end

    always @(posedge clk) begin
        if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, giving up", $time, QUIET_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int n;
        int p;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        joint          = '0;
        target_angle   = '0;
        measured_angle = '0;
        for (n = 0; n < mjpid_pkg::JOINT_COUNT; n++)
            setpoint[n] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset gains: angle extremes, derivative kicks, back to back joints
        send_tick(2'd0, ANGLE_MAX, ANGLE_MIN);
        send_tick(2'd1, ANGLE_MIN, ANGLE_MAX);
        send_tick(2'd2, 24'sd0, 24'sd0);
        send_tick(2'd3, 24'sd4096, 24'sd0);
        send_tick(2'd3, 24'sd0, 24'sd4096);
        send_tick(2'd3, 24'sd0, 24'sd4096);
        send_tick(2'd0, 24'sd0, 24'sd0);
        send_tick(2'd2, ANGLE_MAX, ANGLE_MAX);
        send_tick(2'd1, -24'sd1, 24'sd0);
        settle();

        // unit proportional gain: rounding of exact halves
        load_gains(24'd1, '0, '0, LIMIT_MAX);
        send_tick(2'd0, 24'sd524288, 24'sd0);
        send_tick(2'd0, -24'sd524288, 24'sd0);
        send_tick(2'd1, 24'sd1572864, 24'sd0);
        send_tick(2'd1, -24'sd1572864, 24'sd0);
        send_tick(2'd2, 24'sd524287, 24'sd0);
        settle();

        // drive exactly at and just past the clamp
        load_gains(24'h10_0000, '0, '0, 15'd1000);
        send_tick(2'd0, 24'sd1000, 24'sd0);
        send_tick(2'd1, 24'sd1001, 24'sd0);
        send_tick(2'd2, -24'sd1000, 24'sd0);
        send_tick(2'd3, -24'sd1001, 24'sd0);
        settle();

        // zero limit
        load_gains(24'd1, '0, '0, '0);
        send_tick(2'd0, 24'sd0, 24'sd0);
        send_tick(2'd1, 24'sd1, 24'sd0);
        send_tick(2'd2, -24'sd1, 24'sd0);
        settle();

        // pure integrator, full rate: the error sum climbs with the largest
        // steps, falls past zero, then climbs back
        load_gains('0, 24'd1, '0, LIMIT_MAX);
        sink_steady = 1'b1;
        sink_pace   = PACE_FULL;
        src_pace    = PACE_FULL;
        for (n = 0; n < RAMP_TICKS; n++)
            send_tick(2'd2, ANGLE_MAX, ANGLE_MIN);
        for (n = 0; n < 2 * RAMP_TICKS; n++)
            send_tick(2'd2, ANGLE_MIN, ANGLE_MAX);
        for (n = 0; n < RAMP_TICKS; n++)
            send_tick(2'd2, ANGLE_MAX, ANGLE_MIN);
        settle();
        sink_steady = 1'b0;

        for (p = 0; p < NUM_PHASES; p++) begin
            settle();
            case (p)
                0: load_gains(mjpid_pkg::KP_RESET, mjpid_pkg::KI_DT_RESET,
                              mjpid_pkg::KD_OVER_DT_RESET, mjpid_pkg::OUTPUT_LIMIT_RESET);
                1: load_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, LIMIT_MAX);
                2: load_gains('0, '0, '0, '0);
                default: load_gains(pick_gain(), pick_gain(), pick_gain(), pick_limit());
            endcase
            src_pace = t_pace'($urandom_range(2));
            if (p == 3) begin
                // receiver backs off while ticks keep coming
                src_pace = PACE_FULL;
                sink_hold_req = 1'b1;
            end
            for (n = 0; n < PHASE_TICKS; n++)
                tracking_tick();
        end
        settle();

        $display("%0d control ticks over %0d gain settings, with an integrator ramp",
                 ticks_sent, gain_sets + 1);
        $display("%0d drive values compared, %0d mismatches", compared, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
